FILE: sv/sks_pkg.sv
// Shared types and codes for the sorted key set unit.
package sks_pkg;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_CHECK  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOCHANGE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_CLEAR,
        OP_CHECK,
        OP_READ,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t          op;
        logic [127:0] key;
        logic [7:0]   pos;
    } item_t;

endpackage

FILE: sv/sks_front.sv
// Command front end: decodes items and queues them for the back end.
module sks_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        cmd,
    input  logic [63:0]       key_high,
    input  logic [63:0]       key_low,
    input  logic [7:0]        position,
    output logic              q_valid,
    output sks_pkg::item_t    q_item,
    input  logic              q_pop
);

    sks_pkg::item_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    sks_pkg::item_t new_item;
    logic           push;
    logic           pop;

    always_comb
    begin
        new_item.key = {key_high, key_low};
        new_item.pos = position;
        unique case (cmd)
            sks_pkg::CMD_INSERT: new_item.op = sks_pkg::OP_INSERT;
            sks_pkg::CMD_REMOVE: new_item.op = sks_pkg::OP_REMOVE;
            sks_pkg::CMD_CLEAR:  new_item.op = sks_pkg::OP_CLEAR;
            sks_pkg::CMD_CHECK:  new_item.op = sks_pkg::OP_CHECK;
            sks_pkg::CMD_READ:   new_item.op = sks_pkg::OP_READ;
            default:             new_item.op = sks_pkg::OP_BAD;
        endcase
    end

    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_pop && q_valid;
    assign q_item  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/sks_back.sv
// Command back end: key table, binary search and entry shifting.
module sks_back #(
    parameter int CAPACITY = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  sks_pkg::item_t    q_item,
    output logic              q_pop,
    output logic              done,
    output logic [1:0]        status,
    output logic [7:0]        slot,
    output logic [63:0]       read_high,
    output logic [63:0]       read_low,
    output logic [8:0]        entries
);

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SRCH     = 6'b000010,
        S_SRCH_CMP = 6'b000100,
        S_SHIFT_RD = 6'b001000,
        S_SHIFT_WR = 6'b010000,
        S_READ     = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    sks_pkg::op_t    op_reg, op_next;
    logic [127:0]    key_reg, key_next;
    logic [7:0]      pos_reg, pos_next;
    logic [FW-1:0]   lo_reg, lo_next;
    logic [FW-1:0]   hi_reg, hi_next;
    logic [FW-1:0]   mid_reg, mid_next;
    logic [FW-1:0]   cur_reg, cur_next;
    logic [FW-1:0]   at_reg, at_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic            done_reg, done_next;
    logic [1:0]      status_reg, status_next;
    logic [7:0]      slot_reg, slot_next;
    logic [127:0]    rkey_reg, rkey_next;

    logic [127:0]    mem [CAPACITY];
    logic [127:0]    rdata_reg;
    logic [AW-1:0]   raddr;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [127:0]    wdata;

    logic [FW-1:0]   mid;
    logic [FW+7:0]   posx;
    logic [FW+7:0]   fillx;
    logic [FW+7:0]   fill_ext;

    function automatic logic [7:0] slot_of(input logic [FW-1:0] v);
        logic [FW+7:0] t;
        t = {8'd0, v};
        return t[7:0];
    endfunction

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign posx     = {{FW{1'b0}}, pos_reg};
    assign fillx    = {8'd0, fill_reg};
    assign fill_ext = {8'd0, fill_reg};

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        cur_next    = cur_reg;
        at_next     = at_reg;
        fill_next   = fill_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;
        rkey_next   = rkey_reg;
        q_pop       = 1'b0;
        raddr       = mid[AW-1:0];
        we          = 1'b0;
        waddr       = cur_reg[AW-1:0];
        wdata       = rdata_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    op_next  = q_item.op;
                    key_next = q_item.key;
                    pos_next = q_item.pos;
                    lo_next  = '0;
                    hi_next  = fill_reg;
                    case (q_item.op) inside
                        sks_pkg::OP_INSERT, sks_pkg::OP_REMOVE, sks_pkg::OP_CHECK:
                        begin
                            state_next = S_SRCH;
                        end
                        sks_pkg::OP_CLEAR:
                        begin
                            fill_next   = '0;
                            done_next   = 1'b1;
                            status_next = sks_pkg::ST_OK;
                            slot_next   = 8'd0;
                            rkey_next   = '0;
                        end
                        sks_pkg::OP_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = sks_pkg::ST_NOCHANGE;
                            slot_next   = 8'd0;
                            rkey_next   = '0;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                raddr = posx[AW-1:0];
                if (posx < fillx)
                begin
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = sks_pkg::ST_NOCHANGE;
                    slot_next   = 8'd0;
                    rkey_next   = '0;
                end
            end

            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid;
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    at_next   = lo_reg;
                    rkey_next = '0;
                    if (op_reg == sks_pkg::OP_INSERT)
                    begin
                        if (fill_reg == FW'(CAPACITY))
                        begin
                            state_next  = S_IDLE;
                            done_next   = 1'b1;
                            status_next = sks_pkg::ST_FULL;
                            slot_next   = 8'd0;
                        end
                        else
                        begin
                            cur_next   = fill_reg;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    else
                    begin
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                        status_next = sks_pkg::ST_NOCHANGE;
                        slot_next   = 8'd0;
                    end
                end
            end

            S_SRCH_CMP:
            begin
                if (key_reg == rdata_reg)
                begin
                    at_next   = mid_reg;
                    rkey_next = '0;
                    slot_next = slot_of(mid_reg);
                    case (op_reg)
                        sks_pkg::OP_INSERT:
                        begin
                            state_next  = S_IDLE;
                            done_next   = 1'b1;
                            status_next = sks_pkg::ST_NOCHANGE;
                        end
                        sks_pkg::OP_REMOVE:
                        begin
                            cur_next   = mid_reg;
                            state_next = S_SHIFT_RD;
                        end
                        default:
                        begin
                            state_next  = S_IDLE;
                            done_next   = 1'b1;
                            status_next = sks_pkg::ST_OK;
                        end
                    endcase
                end
                else
                begin
                    if (key_reg < rdata_reg)
                    begin
                        hi_next = mid_reg;
                    end
                    else
                    begin
                        lo_next = mid_reg + FW'(1);
                    end
                    state_next = S_SRCH;
                end
            end

            S_SHIFT_RD:
            begin
                if (op_reg == sks_pkg::OP_INSERT)
                begin
                    raddr = cur_reg[AW-1:0] - AW'(1);
                    if (cur_reg == at_reg)
                    begin
                        we          = 1'b1;
                        waddr       = at_reg[AW-1:0];
                        wdata       = key_reg;
                        fill_next   = fill_reg + FW'(1);
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                        status_next = sks_pkg::ST_OK;
                        slot_next   = slot_of(at_reg);
                    end
                    else
                    begin
                        state_next = S_SHIFT_WR;
                    end
                end
                else
                begin
                    raddr = cur_reg[AW-1:0] + AW'(1);
                    if ((cur_reg + FW'(1)) >= fill_reg)
                    begin
                        fill_next   = fill_reg - FW'(1);
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                        status_next = sks_pkg::ST_OK;
                        slot_next   = slot_of(at_reg);
                    end
                    else
                    begin
                        state_next = S_SHIFT_WR;
                    end
                end
            end

            S_SHIFT_WR:
            begin
                if (op_reg == sks_pkg::OP_READ)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = sks_pkg::ST_OK;
                    slot_next   = pos_reg;
                    rkey_next   = rdata_reg;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_SHIFT_RD;
                    if (op_reg == sks_pkg::OP_INSERT)
                    begin
                        cur_next = cur_reg - FW'(1);
                    end
                    else
                    begin
                        cur_next = cur_reg + FW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        cur_reg    <= cur_next;
        at_reg     <= at_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        rkey_reg   <= rkey_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign read_high = rkey_reg[127:64];
    assign read_low  = rkey_reg[63:0];
    assign entries   = fill_ext[8:0];

endmodule

FILE: sv/sorted_key_set_unit.sv
// Read passes S_READ, S_SHIFT_WR; check, insert and remove probe in S_SRCH/S_SRCH_CMP,
// at most ceil(log2(n+1)) probes; insert and remove then shift via S_SHIFT_RD/S_SHIFT_WR.
// Flow: one item in the back end at a time; a 2-item queue takes items meanwhile.
// busy is high only while that queue is full; done pulses one cycle per result.
// Reset (async, rst_n low) empties the set and the queue; the table itself is not cleared.
module sorted_key_set_unit #(
    parameter int CAPACITY = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [63:0] key_high,
    input  logic [63:0] key_low,
    input  logic [7:0]  position,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  slot,
    output logic [63:0] read_high,
    output logic [63:0] read_low,
    output logic [8:0]  entries
);

    logic           q_valid;
    logic           q_pop;
    sks_pkg::item_t q_item;

    sks_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .key_high (key_high),
        .key_low  (key_low),
        .position (position),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    sks_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .done      (done),
        .status    (status),
        .slot      (slot),
        .read_high (read_high),
        .read_low  (read_low),
        .entries   (entries)
    );

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == sks_pkg::ST_OK || status == sks_pkg::ST_NOCHANGE
                  || status == sks_pkg::ST_FULL))
        else $error("bad status code");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != sks_pkg::ST_OK) |-> (read_high == 64'd0 && read_low == 64'd0))
        else $error("read data on failed command");

    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == sks_pkg::ST_FULL) |-> (slot == 8'd0))
        else $error("nonzero slot on full");

endmodule

FILE: verif/sks_checker.sv
// Checker for the sorted key set unit: tracks the set and compares every result.
`timescale 1ns / 1ps
module sks_checker #(
    parameter int CAPACITY = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  cmd,
    input  logic [63:0] key_high,
    input  logic [63:0] key_low,
    input  logic [7:0]  position,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [7:0]  slot,
    input  logic [63:0] read_high,
    input  logic [63:0] read_low,
    input  logic [8:0]  entries,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [1:0]   status;
        logic [7:0]   slot;
        logic [127:0] rkey;
        logic [8:0]   entries;
    } answer_t;

    logic [127:0] keys[$];
    answer_t      answers[$];

    assign pending = answers.size();

    // binary search; returns 1 when present, where = hit or insertion point
    function automatic bit find_key(input logic [127:0] k, output int where);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = keys.size();
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (k == keys[mid])
            begin
                where = mid;
                return 1'b1;
            end
            if (k < keys[mid])
                hi = mid;
            else
                lo = mid + 1;
        end
        where = lo;
        return 1'b0;
    endfunction

    function automatic answer_t apply_cmd(input logic [2:0] c, input logic [127:0] k,
                                          input logic [7:0] p);
        answer_t a;
        int at;
        bit hit;
        a = '0;
        a.status = sks_pkg::ST_NOCHANGE;
        case (c)
            sks_pkg::CMD_INSERT:
            begin
                hit = find_key(k, at);
                if (hit)
                    a.slot = at[7:0];
                else if (keys.size() >= CAPACITY)
                    a.status = sks_pkg::ST_FULL;
                else
                begin
                    keys.insert(at, k);
                    a.status = sks_pkg::ST_OK;
                    a.slot = at[7:0];
                end
            end
            sks_pkg::CMD_REMOVE:
            begin
                hit = find_key(k, at);
                if (hit)
                begin
                    keys.delete(at);
                    a.status = sks_pkg::ST_OK;
                    a.slot = at[7:0];
                end
            end
            sks_pkg::CMD_CLEAR:
            begin
                keys.delete();
                a.status = sks_pkg::ST_OK;
            end
            sks_pkg::CMD_CHECK:
            begin
                hit = find_key(k, at);
                if (hit)
                begin
                    a.status = sks_pkg::ST_OK;
                    a.slot = at[7:0];
                end
            end
            sks_pkg::CMD_READ:
            begin
                if (int'(p) < keys.size())
                begin
                    a.status = sks_pkg::ST_OK;
                    a.slot = p;
                    a.rkey = keys[p];
                end
            end
            default:
            begin
            end
        endcase
        a.entries = 9'(keys.size());
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            keys.delete();
            answers.delete();
        end
        else
        begin
            if (done)
            begin
                got = {status, slot, read_high, read_low, entries};
                if (answers.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = answers.pop_front();
                    if (got !== want)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display({"mismatch: exp st=%0d slot=%0d key=%h n=%0d,",
                                      " got st=%0d slot=%0d key=%h n=%0d"},
                                want.status, want.slot, want.rkey, want.entries,
                                got.status, got.slot, got.rkey, got.entries);
                    end
                end
            end
            if (start && !busy)
                answers.push_back(apply_cmd(cmd, {key_high, key_low}, position));
        end
    end

endmodule

FILE: verif/sorted_key_set_unit_tb.sv
// Testbench top for the sorted key set unit: stimulus and verdict.
`timescale 1ns / 1ps
module sorted_key_set_unit_tb;

    localparam int CAPACITY = 256;
    localparam int CYCLE_LIMIT = 4000000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  cmd;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [7:0]  position;
    logic        done;
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [63:0] read_high;
    logic [63:0] read_low;
    logic [8:0]  entries;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          calm;
    logic [127:0] pool[16];

    sorted_key_set_unit #(.CAPACITY(CAPACITY)) u_top (.*);

    sks_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // start stays high between items unless an idle cycle is drawn
    task automatic send_item(input logic [2:0] c, input logic [127:0] k, input logic [7:0] p);
        while (!calm && $urandom_range(99) < 28)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        key_high <= k[127:64];
        key_low <= k[63:0];
        position <= p;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [127:0] rand_key();
        logic [127:0] k;
        k = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(3))
            0: k = pool[$urandom_range(15)];
            1: k = pool[$urandom_range(15)] ^ (128'd1 << $urandom_range(127));
            default:
            begin
            end
        endcase
        return k;
    endfunction

    initial
    begin
        logic [2:0] c;
        int r;
        calm = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = sks_pkg::CMD_INSERT;
        key_high = '0;
        key_low = '0;
        position = '0;
        for (int i = 0; i < 16; i++)
            pool[i] = {$urandom, $urandom, $urandom, $urandom};
        pool[0] = '0;
        pool[1] = '1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(sks_pkg::CMD_READ, '0, 8'd0);
        send_item(sks_pkg::CMD_CHECK, '0, 8'd0);
        send_item(sks_pkg::CMD_REMOVE, '1, 8'd0);
        send_item(sks_pkg::CMD_INSERT, '1, 8'd0);
        send_item(sks_pkg::CMD_INSERT, '0, 8'd0);
        send_item(sks_pkg::CMD_INSERT, {64'd5, 64'hFFFF_FFFF_FFFF_FFFF}, 8'd0);
        send_item(sks_pkg::CMD_INSERT, {64'd6, 64'd0}, 8'd0);
        send_item(sks_pkg::CMD_INSERT, '0, 8'd0);
        send_item(sks_pkg::CMD_CHECK, '1, 8'd0);
        send_item(sks_pkg::CMD_READ, '0, 8'd3);
        send_item(sks_pkg::CMD_READ, '0, 8'd4);
        send_item(sks_pkg::CMD_READ, '0, 8'd255);
        send_item(3'd5, '1, 8'd0);
        send_item(3'd6, '0, 8'd0);
        send_item(3'd7, '1, 8'd255);
        send_item(sks_pkg::CMD_REMOVE, '0, 8'd0);
        send_item(sks_pkg::CMD_REMOVE, '0, 8'd0);
        send_item(sks_pkg::CMD_CLEAR, '1, 8'd0);
        send_item(sks_pkg::CMD_READ, '0, 8'd0);

        // fill to capacity, probe the full table, read from it, then clear it
        for (int i = 0; i < CAPACITY; i++)
            send_item(sks_pkg::CMD_INSERT, {$urandom, $urandom, $urandom, $urandom}, 8'd0);
        send_item(sks_pkg::CMD_INSERT, {$urandom, $urandom, $urandom, $urandom}, 8'd0);
        send_item(sks_pkg::CMD_READ, '0, 8'd255);
        for (int i = 0; i < 40; i++)
            send_item(sks_pkg::CMD_READ, '0, 8'($urandom_range(255)));
        send_item(sks_pkg::CMD_CLEAR, '0, 8'd0);

        for (int n = 0; n < 1400; n++)
        begin
            calm = (n >= 500 && n < 700);
            r = $urandom_range(99);
            if (r < 35)
                c = sks_pkg::CMD_INSERT;
            else if (r < 55)
                c = sks_pkg::CMD_REMOVE;
            else if (r < 75)
                c = sks_pkg::CMD_CHECK;
            else if (r < 95)
                c = sks_pkg::CMD_READ;
            else if (r < 97)
                c = sks_pkg::CMD_CLEAR;
            else
                c = 3'($urandom_range(7));
            send_item(c, rand_key(), 8'($urandom_range(r < 90 ? 40 : 255)));
        end
        calm = 1'b0;
        start <= 1'b0;

        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sorted_key_set_unit.f
sv/sks_pkg.sv
sv/sks_front.sv
sv/sks_back.sv
sv/sorted_key_set_unit.sv
verif/sks_checker.sv
verif/sorted_key_set_unit_tb.sv
